[sv/ept_pkg.sv]
// Shared types and constants of the ellipse tessellator.
// No dependencies.
package ept_pkg;
  localparam int MaxStepsDefault  = 63;
  localparam int AngleBitsDefault = 16;
  localparam int FracBitsDefault  = 18;
  localparam logic [15:0] StepDistanceReset = 16'd16;
  localparam logic [63:0] TwoPiQ16 = 64'd411775;
  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam int CordicMaxIter = 30;
  localparam logic [1:0] RegStepDistance = 2'd0;

  typedef logic [31:0] atan_table_t [CordicMaxIter];
  localparam atan_table_t AtanTurnQ32 = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

  // One CORDIC rotation working set carried along the chain
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               neg;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_bus_t;
endpackage

[sv/ept_if.sv]
// Valid/ready channel interfaces of the ellipse tessellator.
// Depends on nothing.
interface ept_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] center_x;
  logic signed [30:0] center_y;
  logic [28:0]        radius_x;
  logic [28:0]        radius_y;
  logic [15:0]        rotation;
  modport source (output valid, center_x, center_y, radius_x, radius_y, rotation,
                  input ready);
  modport sink (input valid, center_x, center_y, radius_x, radius_y, rotation,
                output ready);
endinterface

interface ept_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[sv/ellipse_polyline_tessellator.sv]
// Top level of the ellipse polyline tessellator: APB register, step count,
// angle sequencer, CORDIC cell chain and point arithmetic.
// Depends on ept_pkg, ept_if, ept_cordic_chain.
//
// One transfer on the input channel is one ellipse. The block first works out
// the step count n (a bit-serial square root of 16*(rx^2+ry^2), one result
// bit per cycle, then a restoring division one quotient bit per cycle, then
// 2^ANGLE_BITS / n the same way for the angle step), then streams the
// rotation angle and n+1 point angles through a chain of CORDIC_FRAC_BITS
// cells, one angle per cycle unless the in-flight limit holds the sequencer;
// the point angles start once the rotation result is back. Each point then
// passes a five-stage multiply path, a 64-entry queue with a registered read
// and the output register; the queue prefetches the next point only after
// handing the last one to the output register. The set-up runs the square
// root, the length, the division and the saturation (both skipped when
// step_distance is 0) and the angle step in turn. One ellipse is in flight
// at a time; the queue absorbs output stalls, which back-pressure the
// sequencer. step_distance at byte address 0 resets to 16.
module ellipse_polyline_tessellator
  import ept_pkg::*;
#(
  parameter int MAX_STEPS        = MaxStepsDefault,
  parameter int ANGLE_BITS       = AngleBitsDefault,
  parameter int CORDIC_FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ept_in_if.sink      in_ch,
  ept_out_if.source   out_ch
);
  localparam int F  = CORDIC_FRAC_BITS;
  localparam int NW = $clog2(MAX_STEPS + 2);
  localparam int LAT = F + 1;

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_LEN, S_DIV, S_DRAIN, S_STEP, S_RUN}
    state_t;

  logic [15:0] step_distance;
  assign pready = 1'b1;
  assign prdata = (paddr == RegStepDistance[0:0]) ? {16'd0, step_distance} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_distance <= StepDistanceReset;
    end else if (psel && penable && pwrite && paddr == RegStepDistance[0:0]) begin
      step_distance <= pwdata[15:0];
    end
  end

  state_t             state;
  logic signed [30:0] held_center_x, held_center_y;
  logic [28:0]        held_radius_x, held_radius_y;
  logic [15:0]        held_rotation;
  logic [NW-1:0]      step_total, step_index;
  logic [63:0]        sq_rem, sq_res, sq_bit;
  logic [5:0]         cnt;
  logic [63:0]        len_q, div_rem, quot;
  logic [1:0]         mcnt;
  logic [NW-1:0]      fill;     // points launched but not yet delivered
  logic [NW-1:0]      issue_k;
  logic               issued_rot;
  logic               rot_done;

  // Sum of squares: sq_rx and sq_ry are registered, then their sum is loaded into sq_rem
  logic [57:0] sq_rx, sq_ry;
  logic [63:0] d_sh;
  assign d_sh = {30'd0, step_distance, 18'd0};

  // Angle numerator k*2^AB + n/2 stepped incrementally
  logic [ANGLE_BITS+NW-1:0] t_q, t_r;
  logic [31:0]              angle;
  logic                     launch;
  logic                     can_launch;

  // Angle t = floor(num/n): kept incrementally, t_q and t_r track num = t_q*n + t_r
  // next k: num += 2^AB, with 2^AB = add_q*n + add_r worked out once per ellipse
  logic [ANGLE_BITS:0] add_q;
  logic [NW-1:0]       add_r;
  logic [NW:0]         recip_try;
  assign recip_try = {add_r, cnt == 6'(ANGLE_BITS)};

  logic chain_out_valid;
  logic signed [33:0] cos_q, sin_q, cos_r, sin_r;
  logic               last_line [LAT];

  // in-flight limit: LAT chain places + 5-stage math pipe + 3 further places
  localparam int PIPE = 5;
  assign can_launch = (fill < NW'(LAT + PIPE + 3)) || (fill == '0);

  always_comb begin
    angle = '0;
    if (!issued_rot) begin
      angle = {held_rotation, 16'd0} & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    end else if (issue_k != step_total) begin
      angle = 32'(t_q) << (32 - ANGLE_BITS);
    end
  end
  assign launch = (state == S_RUN) && can_launch &&
                  (!issued_rot || issue_k <= step_total) &&
                  (issued_rot ? rot_done : 1'b1);
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued_rot <= 1'b0;
      issue_k    <= '0;
      step_total <= '0;
      step_index <= '0;
      cnt        <= '0;
      mcnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            held_center_x <= in_ch.center_x;
            held_center_y <= in_ch.center_y;
            held_radius_x <= in_ch.radius_x;
            held_radius_y <= in_ch.radius_y;
            held_rotation <= in_ch.rotation;
            mcnt  <= '0;
            state <= S_SQRT;
            cnt   <= 6'd0;
          end
        end
        S_SQRT: begin
          if (mcnt == 2'd0) begin
            sq_rx <= 58'(held_radius_x) * 58'(held_radius_x);
            sq_ry <= 58'(held_radius_y) * 58'(held_radius_y);
            mcnt  <= 2'd1;
          end else if (mcnt == 2'd1) begin
            sq_rem <= {1'b0, 59'({1'b0, sq_rx} + {1'b0, sq_ry}), 4'd0};
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            mcnt   <= 2'd2;
          end else if (sq_bit != 64'd0) begin
            if (sq_rem >= sq_res + sq_bit) begin
              sq_rem <= sq_rem - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          len_q   <= 64'(sq_res[31:0]) * TwoPiQ16 + {31'd0, step_distance, 17'd0};
          div_rem <= '0;
          quot    <= '0;
          add_q   <= '0;
          add_r   <= '0;
          cnt     <= (step_distance == 16'd0) ? 6'(ANGLE_BITS) : 6'd63;
          state   <= (step_distance == 16'd0) ? S_STEP : S_DIV;
          if (step_distance == 16'd0) begin
            step_total <= NW'(MAX_STEPS);
          end
        end
        S_DIV: begin
          if ({div_rem[62:0], len_q[cnt]} >= d_sh) begin
            div_rem <= {div_rem[62:0], len_q[cnt]} - d_sh;
            quot    <= {quot[62:0], 1'b1};
          end else begin
            div_rem <= {div_rem[62:0], len_q[cnt]};
            quot    <= {quot[62:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (quot == 64'd0) step_total <= NW'(1);
          else if (quot > 64'(MAX_STEPS)) step_total <= NW'(MAX_STEPS);
          else step_total <= quot[NW-1:0];
          cnt   <= 6'(ANGLE_BITS);
          state <= S_STEP;
        end
        // 2^AB / n, one quotient bit per cycle, MSB first
        S_STEP: begin
          if (recip_try >= {1'b0, step_total}) begin
            add_r <= NW'(recip_try - {1'b0, step_total});
            add_q <= {add_q[ANGLE_BITS-1:0], 1'b1};
          end else begin
            add_r <= recip_try[NW-1:0];
            add_q <= {add_q[ANGLE_BITS-1:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_RUN;
        end
        S_RUN: begin
          if (launch) begin
            if (!issued_rot) begin
              issued_rot <= 1'b1;
              issue_k    <= '0;
            end else begin
              issue_k <= issue_k + NW'(1);
            end
          end
          if (issued_rot && issue_k > step_total && fill == '0 && !out_ch.valid) begin
            issued_rot <= 1'b0;
            step_index <= step_total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // t = round(k*2^AB/n): t_q, t_r hold floor((k*2^AB + n/2)/n) and remainder
  always_ff @(posedge clk) begin
    if (state != S_RUN || !issued_rot) begin
      t_q <= '0;
      t_r <= (ANGLE_BITS+NW)'(step_total >> 1);
    end else if (launch) begin
      if ({1'b0, t_r} + {1'b0, add_r} >= {1'b0, step_total}) begin
        t_q <= t_q + (ANGLE_BITS+NW)'(add_q) + 1'b1;
        t_r <= t_r + add_r - step_total;
      end else begin
        t_q <= t_q + (ANGLE_BITS+NW)'(add_q);
        t_r <= t_r + add_r;
      end
    end
  end

  ept_cordic_chain #(.CORDIC_FRAC_BITS(F)) u_chain (
    .clk(clk), .rst(rst), .in_valid(launch), .angle(angle),
    .out_valid(chain_out_valid), .cos_q(cos_q), .sin_q(sin_q));

  // tag line: marks rotation result and last point, level with the chain
  logic tag_rot [LAT];
  always_ff @(posedge clk) begin
    tag_rot[0]   <= !issued_rot;
    last_line[0] <= issued_rot && issue_k == step_total;
    for (int i = 1; i < LAT; i++) begin
      tag_rot[i]   <= tag_rot[i-1];
      last_line[i] <= last_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state == S_IDLE) rot_done <= 1'b0;
    else if (chain_out_valid && tag_rot[LAT-1]) begin
      rot_done <= 1'b1;
      cos_r    <= cos_q;
      sin_r    <= sin_q;
    end
  end

  // Point pipe
  logic               p1_v, p2_v, p3_v, p4_v, p5_v;
  logic               p1_l, p2_l, p3_l, p4_l, p5_l;
  logic signed [67:0] m_cc, m_ss, m_cs, m_sc;
  logic signed [35:0] cc, ss, cs, sc;
  logic signed [67:0] rxc, rys, rxs, ryc;
  logic signed [67:0] ex, ey;
  logic signed [47:0] sx, sy;
  logic signed [31:0] px, py;
  logic               p1_take;

  assign p1_take = chain_out_valid && !tag_rot[LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0; p5_v <= 1'b0;
    end else begin
      p1_v <= p1_take; p2_v <= p1_v; p3_v <= p2_v; p4_v <= p3_v; p5_v <= p4_v;
    end
    p1_l <= last_line[LAT-1]; p2_l <= p1_l; p3_l <= p2_l; p4_l <= p3_l; p5_l <= p4_l;
    m_cc <= 68'(cos_q) * 68'(cos_r);
    m_ss <= 68'(sin_q) * 68'(sin_r);
    m_cs <= 68'(cos_q) * 68'(sin_r);
    m_sc <= 68'(sin_q) * 68'(cos_r);
    cc <= 36'((m_cc + (68'sd1 <<< (F-1))) >>> F);
    ss <= 36'((m_ss + (68'sd1 <<< (F-1))) >>> F);
    cs <= 36'((m_cs + (68'sd1 <<< (F-1))) >>> F);
    sc <= 36'((m_sc + (68'sd1 <<< (F-1))) >>> F);
    rxc <= signed'({39'd0, held_radius_x}) * 68'(cc);
    rys <= signed'({39'd0, held_radius_y}) * 68'(ss);
    rxs <= signed'({39'd0, held_radius_x}) * 68'(cs);
    ryc <= signed'({39'd0, held_radius_y}) * 68'(sc);
    ex <= rxc - rys + (68'sd1 <<< (F-1));
    ey <= rxs + ryc + (68'sd1 <<< (F-1));
    sx <= 48'(ex >>> F) + 48'(held_center_x);
    sy <= 48'(ey >>> F) + 48'(held_center_y);
  end

  always_comb begin
    px = sx[31:0];
    py = sy[31:0];
    if (sx > 48'sh7fffffff) px = 32'h7fffffff;
    else if (sx < -48'sh80000000) px = 32'h80000000;
    if (sy > 48'sh7fffffff) py = 32'h7fffffff;
    else if (sy < -48'sh80000000) py = 32'h80000000;
  end

  // Output queue (pipe cannot stall; queue absorbs in-flight points)
  localparam int QD = 64;
  logic [64:0] q_mem [QD];
  logic [5:0]  q_wp, q_rp;
  logic [6:0]  q_cnt;
  logic [64:0] q_rd;
  logic        q_rd_v;
  always_ff @(posedge clk) begin
    if (p5_v) q_mem[q_wp] <= {p5_l, px, py};
    if (!q_rd_v) q_rd <= q_mem[q_rp];
  end
  // read data registered: prefetch one entry into q_rd, held until moved out
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp <= '0; q_rp <= '0; q_cnt <= '0; q_rd_v <= 1'b0;
      out_ch.valid <= 1'b0;
      fill <= '0;
    end else begin
      if (p5_v) q_wp <= q_wp + 6'd1;
      if (q_rd_v && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid      <= 1'b1;
        out_ch.point_x    <= q_rd[63:32];
        out_ch.point_y    <= q_rd[31:0];
        out_ch.last_point <= q_rd[64];
        q_rd_v <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
        if (!q_rd_v && q_cnt != 7'd0) begin
          q_rd_v <= 1'b1;
          q_rp   <= q_rp + 6'd1;
        end
      end
      q_cnt <= q_cnt + 7'(p5_v)
             - 7'(!q_rd_v && q_cnt != 7'd0);
      fill <= fill + NW'(launch && issued_rot)
            - NW'(out_ch.valid && out_ch.ready);
    end
  end
endmodule

[sv/ept_cordic_cell.sv]
// One CORDIC iteration cell of the rotation chain.
// Depends on ept_pkg.
module ept_cordic_cell
  import ept_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  cordic_bus_t din,
  output cordic_bus_t dout
);
  cordic_bus_t nxt;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    dx  = din.y >>> STAGE;
    dy  = din.x >>> STAGE;
    at  = signed'({2'b00, AtanTurnQ32[STAGE]});
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.zero <= din.zero;
    dout.neg  <= din.neg;
    dout.x    <= nxt.x;
    dout.y    <= nxt.y;
    dout.z    <= nxt.z;
  end
endmodule

[sv/ept_cordic_chain.sv]
// Row of CORDIC cells: angle in, cos/sin out.
// Depends on ept_pkg and ept_cordic_cell.
module ept_cordic_chain
  import ept_pkg::*;
#(
  parameter int CORDIC_FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        angle,
  output logic               out_valid,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);
  cordic_bus_t link [CORDIC_FRAC_BITS+1];
  logic signed [33:0] za;

  always_comb begin
    za = signed'({{2{angle[31]}}, angle});
    link[0].valid = in_valid;
    link[0].zero  = (angle == 32'd0);
    link[0].neg   = 1'b0;
    if (za > 34'sh40000000) begin
      za = za - 34'sh80000000;
      link[0].neg = 1'b1;
    end else if (za < -34'sh40000000) begin
      za = za + 34'sh80000000;
      link[0].neg = 1'b1;
    end
    link[0].x = signed'({2'b00, GainQ30 >> (30 - CORDIC_FRAC_BITS)});
    link[0].y = '0;
    link[0].z = za;
  end

  for (genvar i = 0; i < CORDIC_FRAC_BITS; i++) begin : g_cell
    ept_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .din(link[i]), .dout(link[i+1]));
  end

  // Final fix-up stage: exact zero angle and half-turn fold
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= link[CORDIC_FRAC_BITS].valid;
    if (link[CORDIC_FRAC_BITS].zero) begin
      cos_q <= 34'sd1 <<< CORDIC_FRAC_BITS;
      sin_q <= '0;
    end else if (link[CORDIC_FRAC_BITS].neg) begin
      cos_q <= -link[CORDIC_FRAC_BITS].x;
      sin_q <= -link[CORDIC_FRAC_BITS].y;
    end else begin
      cos_q <= link[CORDIC_FRAC_BITS].x;
      sin_q <= link[CORDIC_FRAC_BITS].y;
    end
  end
endmodule
